// ===== rtl/pis_pkg.sv =====
// ----------------------------------------------------------------------------
// pis_pkg
// Shared types and constants for the pulse interleave scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pis_pkg;

  // Field widths
  localparam int unsigned TimeW   = 56;
  localparam int unsigned SizeW   = 16;
  localparam int unsigned TagW    = 16;
  localparam int unsigned DurW    = 48;
  localparam int unsigned PulseW  = 16;
  localparam int unsigned RatioW  = 10;
  localparam int unsigned TsW     = 26;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 16;

  // Remainder unit widths: signed dividend, signed remainder
  localparam int unsigned DivW    = 58;
  localparam int unsigned RemW    = 28;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPulseWidth = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgSymbolRatio = 4'd1;

  // Register reset values
  localparam logic [PulseW-1:0] PulseWidthRst = 16'd100;
  localparam logic [RatioW-1:0] SymbolRatioRst = 10'd100;

  typedef enum logic [1:0] {
    OP_TX_REQ  = 2'd0,
    OP_RX_START = 2'd1,
    OP_TX_END  = 2'd2,
    OP_RX_END  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_SENT_NOW   = 3'd0,
    ST_INTERLEAVE = 3'd1,
    ST_NO_GAP     = 3'd2,
    ST_RX_DROPPED = 3'd3,
    ST_RX_KEPT    = 3'd4,
    ST_REMOVED    = 3'd5,
    ST_NOT_FOUND  = 3'd6,
    ST_TABLE_FULL = 3'd7
  } status_e;

  typedef struct packed {
    op_e              op;
    logic [TimeW-1:0] now_fs;
    logic [SizeW-1:0] size_bytes;
    logic [TagW-1:0]  packet_tag;
    logic [TimeW-1:0] match_start_fs;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [TimeW-1:0] tx_start_fs;
    logic [TimeW-1:0] tx_end_fs;
  } rsp_t;

  // Handshake between sequencer and remainder unit
  typedef struct packed {
    logic start;
  } rem_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pis_remdiv.sv =====
// ----------------------------------------------------------------------------
// pis_remdiv
// Shared truncating remainder unit, two dividend bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pis_remdiv (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire pis_pkg::rem_ctrl_t                ctrl_i,
  input  wire logic signed [pis_pkg::DivW-1:0]   dividend_i,
  input  wire logic [pis_pkg::TsW-1:0]           divisor_i,
  output pis_pkg::rem_stat_t                     stat_o,
  output logic signed [pis_pkg::RemW-1:0]        rem_o
);

  localparam int unsigned Steps = pis_pkg::DivW / 2;
  localparam int unsigned CntW  = $clog2(Steps + 1);
  localparam int unsigned RW    = pis_pkg::TsW + 1;

  logic [pis_pkg::DivW-1:0] mag_q, mag_d;
  logic [RW-1:0]            r_q, r_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     neg_q, neg_d;
  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [pis_pkg::TsW-1:0]  div_q, div_d;

  logic [RW-1:0] t1, t2, t1r;

  // Two restoring steps per cycle
  always_comb begin
    t1  = {r_q[pis_pkg::TsW-1:0], mag_q[pis_pkg::DivW-1]};
    t1r = (t1 >= {1'b0, div_q}) ? t1 - {1'b0, div_q} : t1;
    t2  = {t1r[pis_pkg::TsW-1:0], mag_q[pis_pkg::DivW-2]};
    r_d = (t2 >= {1'b0, div_q}) ? t2 - {1'b0, div_q} : t2;
  end

  always_comb begin
    mag_d  = mag_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    done_d = 1'b0;
    div_d  = div_q;
    if (ctrl_i.start) begin
      neg_d  = dividend_i[pis_pkg::DivW-1];
      mag_d  = dividend_i[pis_pkg::DivW-1] ? pis_pkg::DivW'(-dividend_i)
                                           : pis_pkg::DivW'(dividend_i);
      cnt_d  = CntW'(Steps);
      busy_d = 1'b1;
      div_d  = divisor_i;
    end else if (busy_q) begin
      mag_d = {mag_q[pis_pkg::DivW-3:0], 2'b00};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    div_q <= div_d;
    if (ctrl_i.start) begin
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= r_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o = neg_q ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule

`default_nettype wire

// ===== rtl/pulse_interleave_scheduler.sv =====
// ----------------------------------------------------------------------------
// pulse_interleave_scheduler
// Table of ongoing pulse transmissions and receptions with gap scheduling.
// ----------------------------------------------------------------------------
// One request at a time. A transmit request on a table of n entries costs,
// for each entry, one pass of the shared remainder unit (a start, 29 steps
// of two bits each of the 58-bit dividend, and a done strobe) plus an
// insertion into the sorted point list of up to n + 1 steps, followed by a
// gap scan of one point per cycle over the n + 2 sorted points. A receive
// start takes up to one remainder pass per transmit entry; removals scan
// the entries in order and then move each later entry down by one.
// in_stall_o is high from acceptance until the result is loaded into the
// output register; the result register frees the input side as soon as it
// is loaded.
`default_nettype none

module pulse_interleave_scheduler #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire pis_pkg::req_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output pis_pkg::rsp_t                      out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pis_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [pis_pkg::CfgDatW-1:0]   cfg_data_i
);

  localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned NP  = MAX_ENTRIES + 2;
  localparam int unsigned PCW = $clog2(NP + 1);
  localparam int unsigned PIW = $clog2(NP);
  localparam int unsigned RW  = pis_pkg::RemW;
  localparam int unsigned TW  = pis_pkg::TimeW;

  typedef enum logic [14:0] {
    S_IDLE      = 15'b000000000000001,
    S_TS        = 15'b000000000000010,
    S_DUR       = 15'b000000000000100,
    S_DISPATCH  = 15'b000000000001000,
    S_REM_GO    = 15'b000000000010000,
    S_REM_WAIT  = 15'b000000000100000,
    S_INSERT    = 15'b000000001000000,
    S_TS_PT     = 15'b000000010000000,
    S_SCAN_INIT = 15'b000000100000000,
    S_SCAN      = 15'b000001000000000,
    S_RX_CHECK  = 15'b000010000000000,
    S_RX_WAIT   = 15'b000100000000000,
    S_MATCH     = 15'b001000000000000,
    S_SHIFT     = 15'b010000000000000,
    S_DONE      = 15'b100000000000000
  } state_e;

  // ---------------------------------------------------------------- config
  logic [pis_pkg::PulseW-1:0] pulse_width_q;
  logic [pis_pkg::RatioW-1:0] symbol_ratio_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_width_q  <= pis_pkg::PulseWidthRst;
      symbol_ratio_q <= pis_pkg::SymbolRatioRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == pis_pkg::CfgPulseWidth) begin
        pulse_width_q <= cfg_data_i;
      end else if (cfg_index_i == pis_pkg::CfgSymbolRatio) begin
        symbol_ratio_q <= cfg_data_i[pis_pkg::RatioW-1:0];
      end
    end
  end

  // Zero register values act as one
  logic [pis_pkg::PulseW-1:0] pw_eff;
  logic [pis_pkg::RatioW-1:0] ratio_eff;
  assign pw_eff    = (pulse_width_q == '0) ? pis_pkg::PulseW'(1) : pulse_width_q;
  assign ratio_eff = (symbol_ratio_q == '0) ? pis_pkg::RatioW'(1) : symbol_ratio_q;

  // ---------------------------------------------------------------- state
  state_e state_q, state_d;
  pis_pkg::req_t req_q;
  logic [pis_pkg::TsW-1:0]  ts_q, ts_d;
  logic [pis_pkg::DurW-1:0] dur_q, dur_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [PCW-1:0] n_q, n_d;
  logic [PCW-1:0] j_q, j_d;
  logic signed [RW-1:0] v_q, v_d;
  logic signed [RW-1:0] prev_q, prev_d;
  pis_pkg::rsp_t res_q, res_d;
  logic out_valid_q, out_valid_d;
  pis_pkg::rsp_t out_q;

  // Entry table, kept packed in arrival order
  logic                       ent_rx_q    [MAX_ENTRIES];
  logic [TW-1:0]              ent_start_q [MAX_ENTRIES];
  logic [pis_pkg::DurW-1:0]   ent_dur_q   [MAX_ENTRIES];
  logic [pis_pkg::TagW-1:0]   ent_tag_q   [MAX_ENTRIES];

  // Sorted pulse points as offsets from now
  logic signed [RW-1:0] pts_q [NP];

  // Table port
  logic [CW-1:0]            tab_rd_cnt;
  logic [IW-1:0]            tab_rd;
  logic                     tab_we;
  logic [IW-1:0]            tab_wa;
  logic                     tab_w_rx;
  logic [TW-1:0]            tab_w_start;
  logic [pis_pkg::DurW-1:0] tab_w_dur;
  logic [pis_pkg::TagW-1:0] tab_w_tag;
  logic                     rd_rx;
  logic [TW-1:0]            rd_start;
  logic [pis_pkg::DurW-1:0] rd_dur;
  logic [pis_pkg::TagW-1:0] rd_tag;

  assign tab_rd_cnt = (state_q == S_SHIFT) ? idx_q + CW'(1) : idx_q;
  assign tab_rd     = tab_rd_cnt[IW-1:0];
  assign rd_rx      = ent_rx_q[tab_rd];
  assign rd_start   = ent_start_q[tab_rd];
  assign rd_dur     = ent_dur_q[tab_rd];
  assign rd_tag     = ent_tag_q[tab_rd];

  // Point port
  logic [PCW-1:0]       pt_rd_cnt;
  logic [PIW-1:0]       pt_rd;
  logic signed [RW-1:0] pt_rdata;
  logic                 pt_we;
  logic [PCW-1:0]       pt_wa;
  logic signed [RW-1:0] pt_wdata;

  always_comb begin
    pt_rd_cnt = j_q;
    if (state_q == S_INSERT) begin
      pt_rd_cnt = j_q - PCW'(1);
    end else if (state_q == S_SCAN_INIT) begin
      pt_rd_cnt = '0;
    end
  end
  assign pt_rd    = pt_rd_cnt[PIW-1:0];
  assign pt_rdata = pts_q[pt_rd];

  // Remainder unit
  pis_pkg::rem_ctrl_t           rem_ctrl;
  pis_pkg::rem_stat_t           rem_stat;
  logic signed [pis_pkg::DivW-1:0] rem_dividend;
  logic signed [RW-1:0]         rem_val;

  always_comb begin
    rem_dividend = $signed({2'b00, req_q.now_fs}) - $signed({2'b00, rd_start});
    if (req_q.op == pis_pkg::OP_RX_START) begin
      rem_dividend = rem_dividend + $signed({42'd0, pw_eff});
    end
  end

  pis_remdiv u_remdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (rem_ctrl),
    .dividend_i (rem_dividend),
    .divisor_i  (ts_q),
    .stat_o     (rem_stat),
    .rem_o      (rem_val)
  );

  // Signed views of pulse and symbol period
  logic signed [RW-1:0]   pw_s, ts_s, pt_new;
  logic signed [RW:0]     gap_lim, st_off;
  logic [TW-1:0]          st_calc;

  assign pw_s    = $signed({12'd0, pw_eff});
  assign ts_s    = $signed({2'b00, ts_q});
  // Fold the pulse of this entry into the current symbol period
  assign pt_new  = (rem_val < pw_s) ? -rem_val : ts_s - rem_val;
  assign gap_lim = $signed({prev_q[RW-1], prev_q}) + $signed({pw_s, 1'b0});
  assign st_off  = $signed({prev_q[RW-1], prev_q}) + $signed({1'b0, pw_s});
  assign st_calc = req_q.now_fs + {{(TW-RW-1){st_off[RW]}}, st_off};

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d     = state_q;
    ts_d        = ts_q;
    dur_d       = dur_q;
    count_d     = count_q;
    idx_d       = idx_q;
    n_d         = n_q;
    j_d         = j_q;
    v_d         = v_q;
    prev_d      = prev_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    rem_ctrl.start = 1'b0;
    tab_we      = 1'b0;
    tab_wa      = count_q[IW-1:0];
    tab_w_rx    = 1'b0;
    tab_w_start = req_q.now_fs;
    tab_w_dur   = dur_q;
    tab_w_tag   = '0;
    pt_we       = 1'b0;
    pt_wa       = j_q;
    pt_wdata    = pt_rdata;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_TS;
        end
      end
      S_TS: begin
        ts_d    = pis_pkg::TsW'(ratio_eff * pw_eff);
        state_d = S_DUR;
      end
      S_DUR: begin
        dur_d   = pis_pkg::DurW'(req_q.size_bytes * ts_q) << 3;
        state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        res_d  = '{status: pis_pkg::ST_NOT_FOUND, tx_start_fs: '0, tx_end_fs: '0};
        idx_d  = '0;
        unique case (req_q.op)
          pis_pkg::OP_TX_REQ: begin
            if (count_q >= CW'(MAX_ENTRIES)) begin
              res_d.status = pis_pkg::ST_TABLE_FULL;
              state_d      = S_DONE;
            end else if (count_q == '0) begin
              tab_we            = 1'b1;
              count_d           = count_q + CW'(1);
              res_d.status      = pis_pkg::ST_SENT_NOW;
              res_d.tx_start_fs = req_q.now_fs;
              res_d.tx_end_fs   = req_q.now_fs + {{(TW-pis_pkg::DurW){1'b0}}, dur_q};
              state_d           = S_DONE;
            end else begin
              // Point for now itself
              pt_we    = 1'b1;
              pt_wa    = '0;
              pt_wdata = '0;
              n_d      = PCW'(1);
              state_d  = S_REM_GO;
            end
          end
          pis_pkg::OP_RX_START: state_d = S_RX_CHECK;
          pis_pkg::OP_TX_END,
          pis_pkg::OP_RX_END:   state_d = S_MATCH;
        endcase
      end
      S_REM_GO: begin
        rem_ctrl.start = 1'b1;
        state_d        = S_REM_WAIT;
      end
      S_REM_WAIT: begin
        if (rem_stat.done) begin
          v_d     = pt_new;
          j_d     = n_q;
          state_d = S_INSERT;
        end
      end
      // Insertion step: move one larger point up or drop the new one in
      S_INSERT: begin
        pt_we = 1'b1;
        pt_wa = j_q;
        if (j_q != '0 && pt_rdata > v_q) begin
          pt_wdata = pt_rdata;
          j_d      = j_q - PCW'(1);
        end else begin
          pt_wdata = v_q;
          n_d      = n_q + PCW'(1);
          idx_d    = idx_q + CW'(1);
          state_d  = (idx_q + CW'(1) == count_q) ? S_TS_PT : S_REM_GO;
        end
      end
      // Next symbol start is always the largest point
      S_TS_PT: begin
        pt_we    = 1'b1;
        pt_wa    = n_q;
        pt_wdata = ts_s;
        n_d      = n_q + PCW'(1);
        state_d  = S_SCAN_INIT;
      end
      S_SCAN_INIT: begin
        prev_d  = pt_rdata;
        j_d     = PCW'(1);
        state_d = S_SCAN;
      end
      // Gap search over adjacent sorted points
      S_SCAN: begin
        if (prev_q != ts_s && gap_lim <= $signed({pt_rdata[RW-1], pt_rdata})) begin
          tab_we            = 1'b1;
          tab_w_start       = st_calc;
          count_d           = count_q + CW'(1);
          res_d.status      = pis_pkg::ST_INTERLEAVE;
          res_d.tx_start_fs = st_calc;
          res_d.tx_end_fs   = st_calc + {{(TW-pis_pkg::DurW){1'b0}}, dur_q};
          state_d           = S_DONE;
        end else begin
          prev_d = pt_rdata;
          j_d    = j_q + PCW'(1);
          if (j_q == n_q - PCW'(1)) begin
            res_d.status = pis_pkg::ST_NO_GAP;
            state_d      = S_DONE;
          end
        end
      end
      // Half-duplex check against own transmissions
      S_RX_CHECK: begin
        if (idx_q == count_q) begin
          if (count_q >= CW'(MAX_ENTRIES)) begin
            res_d.status = pis_pkg::ST_TABLE_FULL;
          end else begin
            tab_we       = 1'b1;
            tab_w_rx     = 1'b1;
            tab_w_dur    = '0;
            tab_w_tag    = req_q.packet_tag;
            count_d      = count_q + CW'(1);
            res_d.status = pis_pkg::ST_RX_KEPT;
          end
          state_d = S_DONE;
        end else if (rd_rx) begin
          idx_d = idx_q + CW'(1);
        end else begin
          rem_ctrl.start = 1'b1;
          state_d        = S_RX_WAIT;
        end
      end
      S_RX_WAIT: begin
        if (rem_stat.done) begin
          if (rem_val < $signed({pw_s[RW-2:0], 1'b0})) begin
            res_d.status = pis_pkg::ST_RX_DROPPED;
            state_d      = S_DONE;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = S_RX_CHECK;
          end
        end
      end
      // Oldest matching entry is removed
      S_MATCH: begin
        if (idx_q == count_q) begin
          state_d = S_DONE;
        end else if ((req_q.op == pis_pkg::OP_TX_END) ?
                     (!rd_rx && rd_start == req_q.match_start_fs && rd_dur == dur_q) :
                     (rd_rx && rd_tag == req_q.packet_tag)) begin
          state_d = S_SHIFT;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      // Close the gap one entry per cycle
      S_SHIFT: begin
        if (idx_q + CW'(1) < count_q) begin
          tab_we      = 1'b1;
          tab_wa      = idx_q[IW-1:0];
          tab_w_rx    = rd_rx;
          tab_w_start = rd_start;
          tab_w_dur   = rd_dur;
          tab_w_tag   = rd_tag;
          idx_d       = idx_q + CW'(1);
        end else begin
          count_d      = count_q - CW'(1);
          res_d.status = pis_pkg::ST_REMOVED;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      req_q <= in_data_i;
    end
    ts_q   <= ts_d;
    dur_q  <= dur_d;
    idx_q  <= idx_d;
    n_q    <= n_d;
    j_q    <= j_d;
    v_q    <= v_d;
    prev_q <= prev_d;
    res_q  <= res_d;
    if (state_q == S_DONE && out_free) begin
      out_q <= res_q;
    end
    if (tab_we) begin
      ent_rx_q[tab_wa]    <= tab_w_rx;
      ent_start_q[tab_wa] <= tab_w_start;
      ent_dur_q[tab_wa]   <= tab_w_dur;
      ent_tag_q[tab_wa]   <= tab_w_tag;
    end
    if (pt_we) begin
      pts_q[pt_wa[PIW-1:0]] <= pt_wdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/pis_checker.sv =====
// ----------------------------------------------------------------------------
// pis_checker
// Port-level checks for the pulse interleave scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

module pis_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire pis_pkg::rsp_t out_data_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Block is busy after taking a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("ready right after accept");

  // A new result only appears at the end of busy work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a transaction");

  // Times are zero unless a transmission was scheduled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != pis_pkg::ST_SENT_NOW &&
    out_data_o.status != pis_pkg::ST_INTERLEAVE |->
    out_data_o.tx_start_fs == '0 && out_data_o.tx_end_fs == '0)
    else $error("nonzero times on non-schedule result");

endmodule

bind pulse_interleave_scheduler pis_checker u_pis_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== dv/pulse_interleave_scheduler_test.sv =====
// ----------------------------------------------------------------------------
// pulse_interleave_scheduler_test
// Self-checking bench: a queue-fed driver, a random-stall receiver and a
// monitor that checks every result against an in-bench scheduler model.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_interleave_scheduler_test;

  localparam int unsigned NEnt       = 16;
  localparam int unsigned DrainCyc   = 1500;
  localparam int unsigned HoldCyc    = 4000;
  localparam int unsigned HoldAt     = 400;
  localparam longint      CycleLimit = 6000000;
  localparam logic [63:0] Mask56     = 64'h00FF_FFFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pis_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  pis_pkg::rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pis_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [pis_pkg::CfgDatW-1:0] cfg_data = '0;

  pulse_interleave_scheduler #(.MAX_ENTRIES(NEnt)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  // Pending requests and expected responses
  pis_pkg::req_t pend_q[$];
  pis_pkg::rsp_t resp_q[$];
  int   n_acc = 0;
  int   n_err = 0;
  logic in_taken = 1'b0;
  int   send_idle, recv_idle;

  // Scheduler model state
  logic [pis_pkg::PulseW-1:0] m_pw = pis_pkg::PulseWidthRst;
  logic [pis_pkg::RatioW-1:0] m_ratio = pis_pkg::SymbolRatioRst;
  logic        tb_rx[NEnt];
  logic [63:0] tb_start[NEnt];
  logic [63:0] tb_dur[NEnt];
  logic [15:0] tb_tag[NEnt];
  logic [15:0] tb_size[NEnt];
  int          tb_cnt = 0;
  longint      pts[NEnt+2];
  logic [63:0] t_cur = 0;

  function automatic void tbl_add(logic rx, logic [63:0] s, logic [63:0] d,
                                  logic [15:0] tg, logic [15:0] sz);
    tb_rx[tb_cnt] = rx;
    tb_start[tb_cnt] = s & Mask56;
    tb_dur[tb_cnt] = d;
    tb_tag[tb_cnt] = tg;
    tb_size[tb_cnt] = sz;
    tb_cnt++;
  endfunction

  function automatic void tbl_del(int k);
    for (int i = k; i + 1 < tb_cnt; i++) begin
      tb_rx[i] = tb_rx[i+1];
      tb_start[i] = tb_start[i+1];
      tb_dur[i] = tb_dur[i+1];
      tb_tag[i] = tb_tag[i+1];
      tb_size[i] = tb_size[i+1];
    end
    tb_cnt--;
  endfunction

  // Compute the response to one request and update the table
  function automatic pis_pkg::rsp_t schedule(pis_pkg::req_t r);
    pis_pkg::rsp_t o;
    longint pw, ts, now, m, v, a;
    logic [63:0] dur, st;
    int     n, j;
    logic   drop, hit;
    o = '0;
    o.status = pis_pkg::ST_NOT_FOUND;
    pw = (m_pw == 0) ? 1 : longint'(m_pw);
    ts = ((m_ratio == 0) ? 1 : longint'(m_ratio)) * pw;
    now = longint'({8'd0, r.now_fs});
    dur = 64'(r.size_bytes) * 64'd8 * 64'(ts);
    case (r.op)
      pis_pkg::OP_TX_REQ: begin
        if (tb_cnt >= NEnt) begin
          o.status = pis_pkg::ST_TABLE_FULL;
        end else if (tb_cnt == 0) begin
          o.status = pis_pkg::ST_SENT_NOW;
          o.tx_start_fs = r.now_fs;
          o.tx_end_fs = pis_pkg::TimeW'(64'(now) + dur);
          tbl_add(1'b0, 64'(now), dur, 16'd0, r.size_bytes);
        end else begin
          o.status = pis_pkg::ST_NO_GAP;
          n = tb_cnt + 2;
          pts[0] = now;
          pts[n-1] = now + ts;
          for (int i = 0; i < tb_cnt; i++) begin
            m = (now - longint'(tb_start[i])) % ts;
            pts[i+1] = (m < pw) ? now - m : now + ts - m;
          end
          // insertion sort
          for (int i = 1; i < n; i++) begin
            v = pts[i];
            j = i;
            while (j > 0 && pts[j-1] > v) begin
              pts[j] = pts[j-1];
              j--;
            end
            pts[j] = v;
          end
          for (j = 1; j < n; j++) begin
            a = pts[j-1];
            if (a != now + ts && a + 2 * pw <= pts[j]) begin
              st = 64'(a + pw) & Mask56;
              o.status = pis_pkg::ST_INTERLEAVE;
              o.tx_start_fs = pis_pkg::TimeW'(st);
              o.tx_end_fs = pis_pkg::TimeW'(st + dur);
              tbl_add(1'b0, st, dur, 16'd0, r.size_bytes);
              break;
            end
          end
        end
      end
      pis_pkg::OP_RX_START: begin
        drop = 1'b0;
        for (int i = 0; i < tb_cnt; i++) begin
          if (!tb_rx[i] && !drop) begin
            m = (now - longint'(tb_start[i]) + pw) % ts;
            if (m < 2 * pw) drop = 1'b1;
          end
        end
        if (drop) o.status = pis_pkg::ST_RX_DROPPED;
        else if (tb_cnt >= NEnt) o.status = pis_pkg::ST_TABLE_FULL;
        else begin
          o.status = pis_pkg::ST_RX_KEPT;
          tbl_add(1'b1, 64'(now), 64'd0, r.packet_tag, 16'd0);
        end
      end
      default: begin
        for (int i = 0; i < tb_cnt; i++) begin
          if (r.op == pis_pkg::OP_TX_END)
            hit = !tb_rx[i] && tb_start[i] == 64'(r.match_start_fs) &&
                  tb_dur[i] == dur;
          else
            hit = tb_rx[i] && tb_tag[i] == r.packet_tag;
          if (hit) begin
            tbl_del(i);
            o.status = pis_pkg::ST_REMOVED;
            break;
          end
        end
      end
    endcase
    return o;
  endfunction

  task automatic push(pis_pkg::op_e op, logic [63:0] now, logic [15:0] sz,
                      logic [15:0] tg, logic [63:0] ms);
    pis_pkg::req_t r;
    r.op = op;
    r.now_fs = pis_pkg::TimeW'(now);
    r.size_bytes = sz;
    r.packet_tag = tg;
    r.match_start_fs = pis_pkg::TimeW'(ms);
    resp_q.insert(resp_q.size(), schedule(r));
    pend_q.insert(pend_q.size(), r);
  endtask

  // Wait until the block is idle, then write one register
  task automatic write_reg(logic [pis_pkg::CfgIdxW-1:0] idx,
                           logic [pis_pkg::CfgDatW-1:0] val);
    wait (pend_q.size() == 0 && resp_q.size() == 0);
    repeat (DrainCyc) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
    if (idx == pis_pkg::CfgPulseWidth) m_pw = val;
    else m_ratio = pis_pkg::RatioW'(val);
  endtask

  function automatic logic [63:0] rand56();
    return {$urandom, $urandom} & Mask56;
  endfunction

  // Mostly well-formed traffic near a moving time base
  task automatic gen_random(int cnt);
    int    k, sel;
    logic [63:0] ts, now;
    for (int i = 0; i < cnt; i++) begin
      ts = 64'((m_ratio == 0) ? 1 : m_ratio) * 64'((m_pw == 0) ? 1 : m_pw);
      t_cur = (t_cur + 64'($urandom_range(0, 3)) * ts + 64'($urandom_range(0, 255)))
              & Mask56;
      sel = $urandom_range(0, 99);
      if (sel < 3) now = rand56();
      else if (sel < 10) now = (t_cur - 64'($urandom_range(1, 5000))) & Mask56;
      else now = t_cur;
      sel = $urandom_range(0, 99);
      if (sel < 38) begin
        push(pis_pkg::OP_TX_REQ, now, ($urandom_range(0, 9) == 0) ? 16'($urandom)
             : 16'($urandom_range(0, 64)), 16'($urandom), rand56());
      end else if (sel < 62) begin
        push(pis_pkg::OP_RX_START, now, 16'($urandom), 16'($urandom), rand56());
      end else if (sel < 82) begin
        k = (tb_cnt > 0) ? $urandom_range(0, tb_cnt - 1) : 0;
        if (tb_cnt > 0 && !tb_rx[k] && $urandom_range(0, 9) < 8)
          push(pis_pkg::OP_TX_END, now, tb_size[k], 16'($urandom), tb_start[k]);
        else
          push(pis_pkg::OP_TX_END, now, 16'($urandom), 16'($urandom), rand56());
      end else begin
        k = (tb_cnt > 0) ? $urandom_range(0, tb_cnt - 1) : 0;
        if (tb_cnt > 0 && tb_rx[k] && $urandom_range(0, 9) < 8)
          push(pis_pkg::OP_RX_END, now, 16'($urandom), tb_tag[k], rand56());
        else
          push(pis_pkg::OP_RX_END, now, 16'($urandom), 16'($urandom), rand56());
      end
    end
  endtask

  // Stimulus and end of run
  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: empty table, interleave, half-duplex, removals, wrap
    push(pis_pkg::OP_TX_REQ, 64'd0, 16'd0, 16'd0, 64'd0);
    push(pis_pkg::OP_TX_REQ, 64'd10, 16'd3, 16'd0, 64'd0);
    push(pis_pkg::OP_TX_REQ, 64'd20, 16'hFFFF, 16'd0, 64'd0);
    push(pis_pkg::OP_RX_START, 64'd10000, 16'd0, 16'hFFFF, 64'd0);
    push(pis_pkg::OP_RX_START, 64'd10050, 16'd0, 16'd0, 64'd0);
    push(pis_pkg::OP_RX_START, 64'd5, 16'd0, 16'h1234, 64'd0);
    push(pis_pkg::OP_TX_END, 64'd30, 16'd0, 16'd0, 64'd0);
    push(pis_pkg::OP_TX_END, 64'd30, 16'd0, 16'd0, 64'd0);
    push(pis_pkg::OP_TX_END, 64'd30, 16'hFFFF, 16'd0, Mask56);
    push(pis_pkg::OP_RX_END, 64'd40, 16'd0, 16'hFFFF, 64'd0);
    push(pis_pkg::OP_RX_END, 64'd40, 16'd0, 16'hFFFF, 64'd0);
    push(pis_pkg::OP_TX_REQ, 64'd1, 16'd1, 16'd0, 64'd0);
    push(pis_pkg::OP_RX_END, 64'd50, 16'hFFFF, 16'h1234, Mask56);
    push(pis_pkg::OP_TX_END, 64'd50, 16'd3, 16'd0, 64'd120);
    push(pis_pkg::OP_TX_REQ, 64'd60, 16'd1, 16'd0, 64'd0);
    push(pis_pkg::OP_TX_END, 64'd60, 16'd1, 16'd0, 64'd120);
    push(pis_pkg::OP_TX_END, 64'd60, 16'd1, 16'd0, 64'd1);
    push(pis_pkg::OP_TX_REQ, Mask56, 16'hFFFF, 16'hFFFF, Mask56);
    push(pis_pkg::OP_TX_REQ, Mask56 - 64'd50, 16'd2, 16'd0, 64'd0);
    push(pis_pkg::OP_TX_REQ, 64'd0, 16'd2, 16'd0, 64'd0);
    push(pis_pkg::OP_RX_START, Mask56, 16'hFFFF, 16'h00FF, Mask56);
    t_cur = 64'd1000000;
    gen_random(150);
    // extremes, zero registers as one, and a random setting
    write_reg(pis_pkg::CfgPulseWidth, 16'd1);
    write_reg(pis_pkg::CfgSymbolRatio, 16'd1);
    gen_random(100);
    write_reg(pis_pkg::CfgPulseWidth, 16'hFFFF);
    write_reg(pis_pkg::CfgSymbolRatio, 16'h03FF);
    gen_random(130);
    write_reg(pis_pkg::CfgPulseWidth, 16'd0);
    write_reg(pis_pkg::CfgSymbolRatio, 16'd0);
    gen_random(100);
    write_reg(pis_pkg::CfgPulseWidth, 16'd3);
    write_reg(pis_pkg::CfgSymbolRatio, 16'd7);
    gen_random(150);
    write_reg(pis_pkg::CfgPulseWidth, 16'($urandom_range(1, 2000)));
    write_reg(pis_pkg::CfgSymbolRatio, 16'hFC00 | 16'($urandom_range(2, 40)));
    gen_random(150);
    wait (pend_q.size() == 0 && resp_q.size() == 0);
    repeat (DrainCyc) @(posedge clk_i);
    if (n_err == 0 && resp_q.size() == 0) begin
      $display("PASS pulse_interleave_scheduler");
    end else begin
      $display("FAIL pulse_interleave_scheduler");
    end
    $finish;
  end

  // Idle rates per phase of the run
  always_comb begin
    if (n_acc < 280) begin
      send_idle = 31;
      recv_idle = 55;
    end else if (n_acc < 560) begin
      send_idle = 55;
      recv_idle = 31;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  end

  // Driver: new transaction only when the line is free or just taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (pend_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        in_data <= pend_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall plus one long hold-off
  int   hold_cnt = 0;
  logic hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && n_acc >= HoldAt) begin
      hold_cnt <= HoldCyc;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  // Monitor: input acceptance and response checking
  pis_pkg::rsp_t want;
  always @(posedge clk_i) begin
    in_taken <= in_valid && !in_stall;
    if (rst_ni && in_valid && !in_stall) n_acc <= n_acc + 1;
    if (rst_ni && out_valid && !out_stall) begin
      if (resp_q.size() == 0) begin
        $error("unexpected response status=%0d", out_data.status);
        n_err = n_err + 1;
      end else begin
        want = resp_q.pop_front();
        if (out_data.status !== want.status) begin
          $error("status exp=%0d act=%0d", want.status, out_data.status);
          n_err = n_err + 1;
        end
        if (out_data.tx_start_fs !== want.tx_start_fs) begin
          $error("tx_start_fs exp=%0h act=%0h", want.tx_start_fs, out_data.tx_start_fs);
          n_err = n_err + 1;
        end
        if (out_data.tx_end_fs !== want.tx_end_fs) begin
          $error("tx_end_fs exp=%0h act=%0h", want.tx_end_fs, out_data.tx_end_fs);
          n_err = n_err + 1;
        end
      end
    end
  end

  // Watchdog
  longint cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL pulse_interleave_scheduler");
      $finish;
    end
  end

endmodule

`default_nettype wire
